FILE: sv/undirected_graph_cycle_detect_assert.svh
// assertion macros used by the checker file
`ifndef UNDIRECTED_GRAPH_CYCLE_DETECT_ASSERT_SVH
`define UNDIRECTED_GRAPH_CYCLE_DETECT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define UGCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define UGCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ugcd_pkg.sv
// ----------------------------------------------------------------------------
// ugcd_pkg
// Shared widths, defaults and mode codes of the graph cycle detector.
// ----------------------------------------------------------------------------
package ugcd_pkg;

  localparam int MAX_VERTICES_DEF = 32;

  // field widths of the request and register
  localparam int MODE_W  = 2;
  localparam int VTX_W   = 5;
  localparam int COUNT_W = 6;

  // width used for index range compares, holds any count up to 64
  localparam int CMP_W = 8;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADJ    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CYCLE  = 2'd3;

endpackage

FILE: sv/undirected_graph_cycle_detect.sv
// ----------------------------------------------------------------------------
// undirected_graph_cycle_detect
// Symmetric adjacency matrix with edge add/remove, adjacency query and a
// stack-driven depth-first cycle search over the vertices in use.
// ----------------------------------------------------------------------------
// One request is handled at a time. Add and remove read the source row,
// write it while reading the destination row, then write that one (a
// self-loop writes its one row only); an adjacency query answers from the
// source row; a request with a bad endpoint is answered at once. A cycle
// query tries each root vertex, scans one neighbour bit per cycle of each
// visited vertex (up to vertex_count squared bits in total) and on a pop
// reads the frame below, then its row. Results wait in an output register;
// the next request is taken once that register is free or being emptied.
// Per-row valid bits leave the matrix empty after reset, with no clear pass.
module undirected_graph_cycle_detect #(
  parameter int MAX_VERTICES = ugcd_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // register write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ugcd_pkg::COUNT_W-1:0] vertex_count,
  // request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ugcd_pkg::MODE_W-1:0]  mode,
  input  logic [ugcd_pkg::VTX_W-1:0]   src_vertex,
  input  logic [ugcd_pkg::VTX_W-1:0]   dst_vertex,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         answer,
  output logic                         index_error
);
  import ugcd_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UPD_SRC = 3'd1;
  localparam logic [2:0] S_UPD_DST = 3'd2;
  localparam logic [2:0] S_ADJ     = 3'd3;
  localparam logic [2:0] S_ROOT    = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;
  localparam logic [2:0] S_POP     = 3'd6;

  typedef struct packed {
    logic [IDX_W-1:0] vertex;
    logic [IDX_W-1:0] parent;
    logic             has_parent;
    logic [CNT_W-1:0] next;
  } frame_t;

  typedef logic [MAX_VERTICES-1:0] row_t;

  logic [2:0]        state;
  logic [CNT_W-1:0]  live_count;
  logic [MODE_W-1:0] op_mode;
  logic [IDX_W-1:0]  op_src;
  logic [IDX_W-1:0]  op_dst;

  // adjacency memory and its row valid bits
  row_t              adj_mem [MAX_VERTICES];
  row_t              row_valid;
  row_t              adj_rd_data;
  logic              adj_rd_valid;
  logic              adj_rd_en;
  logic [IDX_W-1:0]  adj_rd_addr;
  logic              adj_wr_en;
  logic [IDX_W-1:0]  adj_wr_addr;
  row_t              adj_wr_row;

  // search stack memory, holds the frames below the top one
  frame_t            stk_mem [MAX_VERTICES];
  frame_t            stk_rd_data;
  logic              stk_rd_en;
  logic              stk_wr_en;
  logic [CNT_W-1:0]  depth_m1;

  // search state
  row_t              visited;
  logic [CNT_W-1:0]  root;
  logic [CNT_W-1:0]  depth;
  frame_t            top;

  logic              in_fire;
  logic              in_ok;
  logic              err_take;
  logic [IDX_W-1:0]  src_idx;
  logic [IDX_W-1:0]  dst_idx;
  row_t              cur_row;
  logic [IDX_W-1:0]  scan_idx;
  logic              scan_end;
  logic              edge_hit;
  logic              nb_seen;
  logic              is_parent;
  logic              push;
  logic [CNT_W-1:0]  next_plus;
  logic [IDX_W-1:0]  root_idx;
  logic              root_end;
  logic [IDX_W-1:0]  upd_idx;

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;

  // endpoint range check
  assign src_idx = IDX_W'(src_vertex);
  assign dst_idx = IDX_W'(dst_vertex);
  assign in_ok   = (CMP_W'(src_vertex) < CMP_W'(live_count))
                && (CMP_W'(dst_vertex) < CMP_W'(live_count));

  // flagged request answered at once
  assign err_take = in_fire && (mode != MODE_CYCLE) && !in_ok;

  // row just read, empty when never written
  assign cur_row = adj_rd_valid ? adj_rd_data : '0;

  // neighbour scan of the top frame
  assign scan_idx  = top.next[IDX_W-1:0];
  assign scan_end  = top.next >= live_count;
  assign edge_hit  = cur_row[scan_idx];
  assign nb_seen   = visited[scan_idx];
  assign is_parent = top.has_parent && (top.parent == scan_idx);
  assign push      = (state == S_SCAN) && !scan_end && edge_hit && !nb_seen;
  assign next_plus = top.next + 1'b1;
  assign depth_m1  = depth - 1'b1;

  assign root_idx = root[IDX_W-1:0];
  assign root_end = root >= live_count;

  // adjacency memory port control
  always_comb begin
    adj_rd_en   = 1'b0;
    adj_rd_addr = op_src;
    adj_wr_en   = 1'b0;
    adj_wr_addr = op_src;
    upd_idx     = op_dst;
    unique case (state)
      S_IDLE: begin
        adj_rd_en   = in_fire;
        adj_rd_addr = src_idx;
      end
      S_UPD_SRC: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = op_dst;
        adj_wr_en   = 1'b1;
      end
      S_UPD_DST: begin
        adj_wr_en   = 1'b1;
        adj_wr_addr = op_dst;
        upd_idx     = op_src;
      end
      S_ROOT: begin
        adj_rd_en   = !root_end && !visited[root_idx];
        adj_rd_addr = root_idx;
      end
      S_SCAN: begin
        adj_rd_en   = push;
        adj_rd_addr = scan_idx;
      end
      S_POP: begin
        adj_rd_en   = 1'b1;
        adj_rd_addr = stk_rd_data.vertex;
      end
      default: begin
        adj_rd_en = 1'b0;
      end
    endcase
    if (op_mode == MODE_ADD) begin
      adj_wr_row = cur_row | (row_t'(1) << upd_idx);
    end else begin
      adj_wr_row = cur_row & ~(row_t'(1) << upd_idx);
    end
  end

  // stack memory port control
  assign stk_wr_en = push;
  assign stk_rd_en = (state == S_SCAN) && scan_end && (depth != '0);

  // adjacency memory
  always_ff @(posedge clk) begin
    if (adj_wr_en) begin
      adj_mem[adj_wr_addr] <= adj_wr_row;
    end
    if (adj_rd_en) begin
      adj_rd_data  <= adj_mem[adj_rd_addr];
      adj_rd_valid <= row_valid[adj_rd_addr];
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[depth[IDX_W-1:0]] <= '{vertex:     top.vertex,
                                    parent:     top.parent,
                                    has_parent: top.has_parent,
                                    next:       next_plus};
    end
    if (stk_rd_en) begin
      stk_rd_data <= stk_mem[depth_m1[IDX_W-1:0]];
    end
  end

  // control and search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      out_valid  <= 1'b0;
      row_valid  <= '0;
      visited    <= '0;
      depth      <= '0;
    end else begin
      // register write, counts above the matrix size are clamped
      if (cfg_valid) begin
        if (CMP_W'(vertex_count) > CMP_W'(MAX_VERTICES)) begin
          live_count <= CNT_W'(MAX_VERTICES);
        end else begin
          live_count <= CNT_W'(vertex_count);
        end
      end

      if (out_valid && out_ready && !err_take) begin
        out_valid <= 1'b0;
      end

      if (adj_wr_en) begin
        row_valid[adj_wr_addr] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_mode <= mode;
            op_src  <= src_idx;
            op_dst  <= dst_idx;
            if (mode == MODE_CYCLE) begin
              visited <= '0;
              root    <= '0;
              depth   <= '0;
              state   <= S_ROOT;
            end else if (!in_ok) begin
              out_valid   <= 1'b1;
              answer      <= 1'b0;
              index_error <= 1'b1;
            end else if (mode == MODE_ADJ) begin
              state <= S_ADJ;
            end else begin
              state <= S_UPD_SRC;
            end
          end
        end

        // first row written; a self-loop needs only this one
        S_UPD_SRC: begin
          if (op_src == op_dst) begin
            out_valid   <= 1'b1;
            answer      <= 1'b0;
            index_error <= 1'b0;
            state       <= S_IDLE;
          end else begin
            state <= S_UPD_DST;
          end
        end

        S_UPD_DST: begin
          out_valid   <= 1'b1;
          answer      <= 1'b0;
          index_error <= 1'b0;
          state       <= S_IDLE;
        end

        S_ADJ: begin
          out_valid   <= 1'b1;
          answer      <= cur_row[op_dst];
          index_error <= 1'b0;
          state       <= S_IDLE;
        end

        // pick the next unvisited root
        S_ROOT: begin
          if (root_end) begin
            out_valid   <= 1'b1;
            answer      <= 1'b0;
            index_error <= 1'b0;
            state       <= S_IDLE;
          end else if (visited[root_idx]) begin
            root <= root + 1'b1;
          end else begin
            top                <= '{vertex: root_idx, parent: '0,
                                    has_parent: 1'b0, next: '0};
            visited[root_idx]  <= 1'b1;
            state              <= S_SCAN;
          end
        end

        // one neighbour bit per cycle
        S_SCAN: begin
          if (scan_end) begin
            if (depth == '0) begin
              root  <= root + 1'b1;
              state <= S_ROOT;
            end else begin
              state <= S_POP;
            end
          end else if (push) begin
            depth             <= depth + 1'b1;
            top               <= '{vertex: scan_idx, parent: top.vertex,
                                   has_parent: 1'b1, next: '0};
            visited[scan_idx] <= 1'b1;
          end else begin
            top.next <= next_plus;
            if (edge_hit && nb_seen && !is_parent) begin
              out_valid   <= 1'b1;
              answer      <= 1'b1;
              index_error <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end

        // restore the frame below, its row is read meanwhile
        S_POP: begin
          top   <= stk_rd_data;
          depth <= depth_m1;
          state <= S_SCAN;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/ugcd_checker.sv
// ----------------------------------------------------------------------------
// ugcd_checker
// Port-level checks of the graph cycle detector, bound to the top level.
// ----------------------------------------------------------------------------
`include "undirected_graph_cycle_detect_assert.svh"

module ugcd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic answer,
  input logic index_error
);

  // a stalled result holds its value
  `UGCD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(answer) && $stable(index_error), "stalled result changed")

  // no new request while a result is stuck in the output register
  `UGCD_ASSERT_NOW(a_no_take_stalled, clk, rst, in_valid && in_ready,
    !out_valid || out_ready, "request taken while result stalled")

  // a flagged request never reports adjacency or a cycle
  `UGCD_ASSERT_NOW(a_err_no_answer, clk, rst, out_valid && index_error,
    !answer, "answer set together with index error")

endmodule

bind undirected_graph_cycle_detect ugcd_checker u_ugcd_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the graph cycle detector, mirrors the adjacency matrix
// and the depth-first cycle search in a local model, and compares every
// result field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ugcd_pkg::*;

  localparam int NV          = MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_WAIT  = 16;
  localparam int NUM_PHASES  = 11;

  typedef struct packed {
    logic answer;
    logic index_error;
  } result_t;

  typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_t;

  typedef struct packed {
    step_kind_t             kind;
    logic [MODE_W-1:0]      mode;
    logic [VTX_W-1:0]       src;
    logic [VTX_W-1:0]       dst;
    logic [COUNT_W-1:0]     count;
    logic                   typed;
    result_t                res;
  } table_row_t;

  // dut ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] vertex_count = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode = MODE_ADD;
  logic [VTX_W-1:0]   src_vertex = '0;
  logic [VTX_W-1:0]   dst_vertex = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               answer;
  logic               index_error;

  // local copy of the matrix and the register
  logic [NV-1:0]      graph_rows [NV];
  logic [COUNT_W-1:0] count_setting = '0;

  result_t    expected_results [$];
  table_row_t directed_rows [$];
  result_t    oldest;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int failures        = 0;
  int requests_sent   = 0;
  int cycle_queries   = 0;
  int cyclic_answers  = 0;
  int results_checked = 0;
  int settings_used   = 0;
  int cycle_count     = 0;

  // random phases: register value, sender idle and receiver stall percentages
  int phase_count [NUM_PHASES] = '{32, 5, 1, 12, 63, 0, 2, 20, 33, 64, 8};
  int phase_idle  [NUM_PHASES] = '{0, 66, 0, 15, 0, 66, 0, 15, 66, 0, 0};
  int phase_stall [NUM_PHASES] = '{0, 0, 66, 15, 0, 0, 66, 15, 0, 0, 0};
  int phase_items [NUM_PHASES] = '{110, 100, 40, 120, 100, 30, 60, 120, 100, 90, 80};

  undirected_graph_cycle_detect uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .vertex_count (vertex_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .src_vertex   (src_vertex),
    .dst_vertex   (dst_vertex),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .answer       (answer),
    .index_error  (index_error)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // local model
  // ---------------------------------------------------------------------------

  // register values above the matrix size act as the full size
  function automatic int live_vertices();
    return (count_setting > NV) ? NV : int'(count_setting);
  endfunction

  // explicit-stack depth-first search over the vertices in use
  function automatic logic graph_has_cycle();
    int            n;
    int            depth;
    int            v;
    int            i;
    logic [NV-1:0] seen;
    int            frame_vtx  [NV];
    int            frame_par  [NV];
    logic          frame_root [NV];
    int            frame_scan [NV];
    n = live_vertices();
    seen = '0;
    depth = 0;
    for (int root = 0; root < n; root++) begin
      if (seen[root]) continue;
      frame_vtx[0] = root;
      frame_par[0] = 0;
      frame_root[0] = 1'b1;
      frame_scan[0] = 0;
      seen[root] = 1'b1;
      depth = 1;
      while (depth > 0) begin
        v = frame_vtx[depth-1];
        i = frame_scan[depth-1];
        if (i >= n) begin
          depth--;
          continue;
        end
        frame_scan[depth-1] = i + 1;
        if (!graph_rows[v][i]) continue;
        if (!seen[i]) begin
          frame_vtx[depth] = i;
          frame_par[depth] = v;
          frame_root[depth] = 1'b0;
          frame_scan[depth] = 0;
          seen[i] = 1'b1;
          depth++;
        end else if (frame_root[depth-1] || frame_par[depth-1] != i) begin
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one accepted request to the model and return its result
  function automatic result_t predict_request(input logic [MODE_W-1:0] m,
                                              input logic [VTX_W-1:0] s,
                                              input logic [VTX_W-1:0] d);
    result_t r;
    int      n;
    r = '0;
    n = live_vertices();
    if (m == MODE_CYCLE) begin
      r.answer = graph_has_cycle();
    end else if (int'(s) >= n || int'(d) >= n) begin
      r.index_error = 1'b1;
    end else if (m == MODE_ADD) begin
      graph_rows[s][d] = 1'b1;
      graph_rows[d][s] = 1'b1;
    end else if (m == MODE_REMOVE) begin
      graph_rows[s][d] = 1'b0;
      graph_rows[d][s] = 1'b0;
    end else begin
      r.answer = graph_rows[s][d];
    end
    return r;
  endfunction

  // rough count of edges among the vertices in use
  function automatic int live_edge_total();
    int            n;
    int            total;
    logic [NV-1:0] mask;
    n = live_vertices();
    total = 0;
    mask = (n >= NV) ? '1 : ((NV'(1) << n) - 1);
    for (int r = 0; r < n; r++) total += $countones(graph_rows[r] & mask);
    return total / 2;
  endfunction

  // look for an existing edge between vertices in use
  function automatic logic pick_edge(output logic [VTX_W-1:0] a,
                                     output logic [VTX_W-1:0] b);
    int n;
    n = live_vertices();
    a = '0;
    b = '0;
    for (int t = 0; t < 64; t++) begin
      a = VTX_W'($urandom_range(n - 1));
      b = VTX_W'($urandom_range(n - 1));
      if (graph_rows[a][b]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one request, with a random gap before it
  task automatic send_request(input logic [MODE_W-1:0] m,
                              input logic [VTX_W-1:0] s,
                              input logic [VTX_W-1:0] d,
                              input logic typed,
                              input result_t typed_res);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    src_vertex <= s;
    dst_vertex <= d;
    do @(posedge clk); while (!in_ready);
    predicted = predict_request(m, s, d);
    expected_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
    if (m == MODE_CYCLE) begin
      cycle_queries++;
      if (predicted.answer) cyclic_answers++;
    end
  endtask

  // register write once every outstanding result is back
  task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    cfg_valid    <= 1'b1;
    vertex_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    count_setting  = value;
    settings_used++;
  endtask

  // random request shaped to keep the graph near the tree threshold
  task automatic send_random_request();
    int                n;
    int                pick;
    logic [VTX_W-1:0]  a;
    logic [VTX_W-1:0]  b;
    logic [MODE_W-1:0] m;
    n = live_vertices();
    pick = $urandom_range(99);
    a = VTX_W'($urandom_range(NV - 1));
    b = VTX_W'($urandom_range(NV - 1));
    m = MODE_W'($urandom_range(3));
    if (n == 0 || pick < 8) begin
      // noise over the full field ranges
    end else if (pick < 23) begin
      m = MODE_CYCLE;
    end else if (pick < 43) begin
      m = MODE_ADJ;
      if ($urandom_range(1) == 0 || !pick_edge(a, b)) begin
        a = VTX_W'($urandom_range(n - 1));
        b = VTX_W'($urandom_range(n - 1));
      end
    end else if (live_edge_total() < n - 1 + $urandom_range(2)) begin
      m = MODE_ADD;
      a = VTX_W'($urandom_range(n - 1));
      b = ($urandom_range(19) == 0) ? a : VTX_W'($urandom_range(n - 1));
    end else begin
      m = MODE_REMOVE;
      if (!pick_edge(a, b)) begin
        a = VTX_W'($urandom_range(n - 1));
        b = VTX_W'($urandom_range(n - 1));
      end
    end
    send_request(m, a, b, 1'b0, '0);
  endtask

  task automatic table_request(input logic [MODE_W-1:0] m,
                               input logic [VTX_W-1:0] s,
                               input logic [VTX_W-1:0] d,
                               input logic typed,
                               input logic ans,
                               input logic err);
    table_row_t row;
    row = '0;
    row.kind = STEP_REQUEST;
    row.mode = m;
    row.src = s;
    row.dst = d;
    row.typed = typed;
    row.res.answer = ans;
    row.res.index_error = err;
    directed_rows.push_back(row);
  endtask

  task automatic table_config(input logic [COUNT_W-1:0] c);
    table_row_t row;
    row = '0;
    row.kind = STEP_CONFIG;
    row.count = c;
    directed_rows.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          oldest = expected_results.pop_front();
          if (answer !== oldest.answer) begin
            $error("answer: expected %0d, got %0d", oldest.answer, answer);
            failures++;
          end
          if (index_error !== oldest.index_error) begin
            $error("index_error: expected %0d, got %0d", oldest.index_error, index_error);
            failures++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    table_row_t row;
    int         items;
    for (int r = 0; r < NV; r++) graph_rows[r] = '0;

    // empty graph and bad endpoints with the reset register value
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0);
    table_request(MODE_ADD,    5'd0,  5'd0,  1'b1, 1'b0, 1'b1);
    table_request(MODE_ADJ,    5'd0,  5'd0,  1'b1, 1'b0, 1'b1);
    table_config(6'd4);
    table_request(MODE_ADJ,    5'd0,  5'd1,  1'b1, 1'b0, 1'b0);
    table_request(MODE_ADD,    5'd0,  5'd1,  1'b1, 1'b0, 1'b0);
    table_request(MODE_ADJ,    5'd1,  5'd0,  1'b1, 1'b1, 1'b0);
    table_request(MODE_ADD,    5'd1,  5'd2,  1'b1, 1'b0, 1'b0);
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0);
    // triangle, then broken again
    table_request(MODE_ADD,    5'd2,  5'd0,  1'b1, 1'b0, 1'b0);
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b1, 1'b1, 1'b0);
    table_request(MODE_REMOVE, 5'd0,  5'd2,  1'b1, 1'b0, 1'b0);
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b0, 1'b0, 1'b0);
    // self-loop
    table_request(MODE_ADD,    5'd3,  5'd3,  1'b1, 1'b0, 1'b0);
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b1, 1'b1, 1'b0);
    table_request(MODE_REMOVE, 5'd3,  5'd3,  1'b1, 1'b0, 1'b0);
    // endpoints at or above the count, cycle query operands ignored
    table_request(MODE_ADD,    5'd31, 5'd0,  1'b1, 1'b0, 1'b1);
    table_request(MODE_REMOVE, 5'd0,  5'd31, 1'b1, 1'b0, 1'b1);
    table_request(MODE_ADJ,    5'd3,  5'd4,  1'b1, 1'b0, 1'b1);
    table_request(MODE_CYCLE,  5'd31, 5'd31, 1'b1, 1'b0, 1'b0);
    // oversized count acts as full size
    table_config(6'd63);
    table_request(MODE_ADD,    5'd31, 5'd31, 1'b1, 1'b0, 1'b0);
    table_request(MODE_ADJ,    5'd31, 5'd31, 1'b1, 1'b1, 1'b0);
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b1, 1'b1, 1'b0);
    // stale self-loop beyond the count is ignored by the search
    table_config(6'd3);
    table_request(MODE_CYCLE,  5'd0,  5'd0,  1'b1, 1'b0, 1'b0);
    table_request(MODE_ADJ,    5'd31, 5'd31, 1'b1, 1'b0, 1'b1);
    table_request(MODE_REMOVE, 5'd31, 5'd31, 1'b1, 1'b0, 1'b1);

    // reset
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == STEP_CONFIG) write_vertex_count(row.count);
      else send_request(row.mode, row.src, row.dst, row.typed, row.res);
    end

    // random phases, each under its own register value and idling mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (phase_count[p] > 63) write_vertex_count(COUNT_W'($urandom_range(63)));
      else write_vertex_count(COUNT_W'(phase_count[p]));
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      items = phase_items[p];
      for (int k = 0; k < items; k++) send_random_request();
    end

    // drain
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d requests, %0d results checked, %0d register settings",
             requests_sent, results_checked, settings_used);
    $display("%0d cycle searches, %0d of them found a cycle",
             cycle_queries, cyclic_answers);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", failures);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/ugcd_pkg.sv
sv/undirected_graph_cycle_detect.sv
sv/ugcd_checker.sv
tb/testbench.sv
